// ----- design/gbk_pkg.sv -----
// ----------------------------------------------------------------------------
// gbk_pkg
// Types, constants and the exp table generator for the Gaussian RBF kernel
// core.
// ----------------------------------------------------------------------------
`default_nettype none

package gbk_pkg;

    // field widths
    localparam int COORD_W  = 16;
    localparam int INV_W    = 24;
    localparam int KERNEL_W = 17;
    localparam int DIST_W   = 42;

    // shared multiplier
    localparam int MUL_W = 32;

    // exp table: 2^(-k/size) in Q.32 for k = 0 .. size
    localparam int EXP_TABLE_BITS = 8;
    localparam int EXP_TABLE_SIZE = 1 << EXP_TABLE_BITS;
    localparam int EXP_ADDR_W     = EXP_TABLE_BITS + 1;
    localparam int EXP_VAL_W      = 33;
    localparam int TAYLOR_TERMS   = 24;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

    // kernel argument above 32.0 (Q.32) underflows to zero
    localparam int X_W = 66;
    localparam logic [X_W-1:0] X_CAP_Q32 = 66'd1 << 37;

    // exponent at or above this gives zero
    localparam logic [5:0] N_LIMIT = 6'd17;

    localparam logic [KERNEL_W-1:0] KERNEL_ONE = 17'd65536;
    localparam logic [DIST_W-1:0]   ACC_MAX    = {DIST_W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_XLO,
        S_XHI,
        S_XSUM,
        S_LOG,
        S_SPLIT,
        S_TAB0,
        S_TAB1,
        S_DIFF,
        S_IMUL,
        S_INTERP,
        S_ROUND,
        S_PUSH
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQ,
        MUL_XLO,
        MUL_XHI,
        MUL_LOG,
        MUL_INTERP
    } mul_op_t;

    typedef struct packed {
        logic    in_ready;
        mul_op_t mul_op;
        logic    acc_step;
        logic    x_lo_load;
        logic    x_sum_load;
        logic    split_load;
        logic    rom_next;
        logic    t0_load;
        logic    diff_load;
        logic    v_load;
        logic    round_load;
        logic    kern_one;
        logic    kern_zero;
        logic    push;
    } ctrl_t;

    typedef struct packed {
        logic pair_valid;
        logic last;
        logic trivial;
        logic x_over;
        logic n_over;
        logic out_free;
    } stat_t;

    // term / i for the series steps, each divisor a literal
    function automatic logic [63:0] div_by_step(input logic [63:0] t, input int unsigned i);
        logic [63:0] q;
        case (i)
            1:  q = t / 1;
            2:  q = t / 2;
            3:  q = t / 3;
            4:  q = t / 4;
            5:  q = t / 5;
            6:  q = t / 6;
            7:  q = t / 7;
            8:  q = t / 8;
            9:  q = t / 9;
            10: q = t / 10;
            11: q = t / 11;
            12: q = t / 12;
            13: q = t / 13;
            14: q = t / 14;
            15: q = t / 15;
            16: q = t / 16;
            17: q = t / 17;
            18: q = t / 18;
            19: q = t / 19;
            20: q = t / 20;
            21: q = t / 21;
            22: q = t / 22;
            23: q = t / 23;
            24: q = t / 24;
            default: q = t;
        endcase
        return q;
    endfunction

    // exp(-k*ln2/size) by truncated taylor series, Q.32
    function automatic logic [EXP_VAL_W-1:0] exp_entry(input int unsigned k);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        int unsigned i;
        z    = (64'(k) * 64'(LN2_Q32)) >> EXP_TABLE_BITS;
        term = 64'd1 << 32;
        sum  = term;
        for (i = 1; i <= TAYLOR_TERMS; i++)
        begin
            term = div_by_step((term * z) >> 32, i);
            if (i[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum[EXP_VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/gbk_if.sv -----
// ----------------------------------------------------------------------------
// gbk channel interfaces
// Valid/ready channels for coordinate pairs, results and the register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbk_pair_if;
    logic                                valid;
    logic                                ready;
    logic signed [gbk_pkg::COORD_W-1:0]  coord_a;
    logic signed [gbk_pkg::COORD_W-1:0]  coord_b;
    logic                                last;

    modport source (output valid, output coord_a, output coord_b, output last, input ready);
    modport sink   (input valid, input coord_a, input coord_b, input last, output ready);
endinterface

interface gbk_result_if;
    logic                            valid;
    logic                            ready;
    logic [gbk_pkg::KERNEL_W-1:0]    kernel_value;
    logic [gbk_pkg::DIST_W-1:0]      sq_distance;

    modport source (output valid, output kernel_value, output sq_distance, input ready);
    modport sink   (input valid, input kernel_value, input sq_distance, output ready);
endinterface

interface gbk_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gbk_pkg::INV_W-1:0]   inv_bandwidth;

    modport source (output valid, output inv_bandwidth, input ready);
    modport sink   (input valid, input inv_bandwidth, output ready);
endinterface

`default_nettype wire

// ----- design/gbk_mul.sv -----
// ----------------------------------------------------------------------------
// gbk_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module gbk_mul (
    input  wire logic                          clk,
    input  wire logic [gbk_pkg::MUL_W-1:0]     a,
    input  wire logic [gbk_pkg::MUL_W-1:0]     b,
    output logic      [2*gbk_pkg::MUL_W-1:0]   p
);

    logic [2*gbk_pkg::MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- design/gbk_exp_rom.sv -----
// ----------------------------------------------------------------------------
// gbk_exp_rom
// Constant table of 2^(-k/size) in Q.32 with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gbk_exp_rom (
    input  wire logic                              clk,
    input  wire logic [gbk_pkg::EXP_ADDR_W-1:0]    addr,
    output logic      [gbk_pkg::EXP_VAL_W-1:0]     q
);

    logic [gbk_pkg::EXP_VAL_W-1:0] exp_tab [0:gbk_pkg::EXP_TABLE_SIZE];
    logic [gbk_pkg::EXP_VAL_W-1:0] q_reg;

    for (genvar k = 0; k <= gbk_pkg::EXP_TABLE_SIZE; k++)
    begin : g_entry
        assign exp_tab[k] = gbk_pkg::exp_entry(k);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= exp_tab[addr];
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ----- design/gbk_seq.sv -----
// ----------------------------------------------------------------------------
// gbk_seq
// Sequencer: steps the datapath through square, accumulate and kernel steps.
// ----------------------------------------------------------------------------
`default_nettype none

module gbk_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gbk_pkg::stat_t   stat,
    output gbk_pkg::ctrl_t        ctrl
);

    gbk_pkg::state_t state_reg;
    gbk_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gbk_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbk_pkg::S_IDLE:
            begin
                if (stat.pair_valid)
                    state_next = gbk_pkg::S_SQ;
            end
            gbk_pkg::S_SQ:     state_next = gbk_pkg::S_ACC;
            gbk_pkg::S_ACC:
            begin
                if (stat.last)
                    state_next = gbk_pkg::S_XLO;
                else
                    state_next = gbk_pkg::S_IDLE;
            end
            gbk_pkg::S_XLO:
            begin
                if (stat.trivial)
                    state_next = gbk_pkg::S_PUSH;
                else
                    state_next = gbk_pkg::S_XHI;
            end
            gbk_pkg::S_XHI:    state_next = gbk_pkg::S_XSUM;
            gbk_pkg::S_XSUM:
            begin
                if (stat.x_over)
                    state_next = gbk_pkg::S_PUSH;
                else
                    state_next = gbk_pkg::S_LOG;
            end
            gbk_pkg::S_LOG:    state_next = gbk_pkg::S_SPLIT;
            gbk_pkg::S_SPLIT:
            begin
                if (stat.n_over)
                    state_next = gbk_pkg::S_PUSH;
                else
                    state_next = gbk_pkg::S_TAB0;
            end
            gbk_pkg::S_TAB0:   state_next = gbk_pkg::S_TAB1;
            gbk_pkg::S_TAB1:   state_next = gbk_pkg::S_DIFF;
            gbk_pkg::S_DIFF:   state_next = gbk_pkg::S_IMUL;
            gbk_pkg::S_IMUL:   state_next = gbk_pkg::S_INTERP;
            gbk_pkg::S_INTERP: state_next = gbk_pkg::S_ROUND;
            gbk_pkg::S_ROUND:  state_next = gbk_pkg::S_PUSH;
            gbk_pkg::S_PUSH:
            begin
                if (stat.out_free)
                    state_next = gbk_pkg::S_IDLE;
            end
            default:           state_next = gbk_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl        = '0;
        ctrl.mul_op = gbk_pkg::MUL_NONE;
        unique case (state_reg)
            gbk_pkg::S_IDLE:   ctrl.in_ready = 1'b1;
            gbk_pkg::S_SQ:     ctrl.mul_op = gbk_pkg::MUL_SQ;
            gbk_pkg::S_ACC:    ctrl.acc_step = 1'b1;
            gbk_pkg::S_XLO:
            begin
                ctrl.mul_op   = gbk_pkg::MUL_XLO;
                ctrl.kern_one = stat.trivial;
            end
            gbk_pkg::S_XHI:
            begin
                ctrl.mul_op    = gbk_pkg::MUL_XHI;
                ctrl.x_lo_load = 1'b1;
            end
            gbk_pkg::S_XSUM:
            begin
                ctrl.x_sum_load = 1'b1;
                ctrl.kern_zero  = stat.x_over;
            end
            gbk_pkg::S_LOG:    ctrl.mul_op = gbk_pkg::MUL_LOG;
            gbk_pkg::S_SPLIT:
            begin
                ctrl.split_load = 1'b1;
                ctrl.kern_zero  = stat.n_over;
            end
            gbk_pkg::S_TAB0:   ctrl.rom_next = 1'b0;
            gbk_pkg::S_TAB1:
            begin
                ctrl.rom_next = 1'b1;
                ctrl.t0_load  = 1'b1;
            end
            gbk_pkg::S_DIFF:   ctrl.diff_load = 1'b1;
            gbk_pkg::S_IMUL:   ctrl.mul_op = gbk_pkg::MUL_INTERP;
            gbk_pkg::S_INTERP: ctrl.v_load = 1'b1;
            gbk_pkg::S_ROUND:  ctrl.round_load = 1'b1;
            gbk_pkg::S_PUSH:   ctrl.push = stat.out_free;
            default:           ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/gaussian_rbf_kernel_core.sv -----
// ----------------------------------------------------------------------------
// gaussian_rbf_kernel_core
// Accumulates squared coordinate differences and evaluates exp(-d2/b) by
// table and interpolation at the end of each vector pair.
// ----------------------------------------------------------------------------
//
//  channel  role  payload                         one transaction
//  pair     sink  coord_a, coord_b, last          one coordinate pair
//  result   src   kernel_value, sq_distance       kernel of one vector pair
//  cfg      sink  inv_bandwidth                   register write, always ready
//
//  a pair without last passes through accept, square and accumulate
//  a pair with last goes on through the kernel steps to push; it skips to push
//  when distance or inv_bandwidth is zero, or when the kernel underflows to zero
//  every product goes through the one shared 32x32 multiplier, one per cycle
//  reset clears the accumulator, sets inv_bandwidth to 2^-17 and empties result
//  a stalled result sits in the output register; pair stays blocked only if a
//  second vector pair finishes before it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_rbf_kernel_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    gbk_pair_if.sink      pair,
    gbk_result_if.source  result,
    gbk_cfg_if.sink       cfg
);

    localparam int TB = gbk_pkg::EXP_TABLE_BITS;
    localparam int MW = gbk_pkg::MUL_W;

    gbk_pkg::ctrl_t ctrl;
    gbk_pkg::stat_t stat;

    // control and config state
    logic [gbk_pkg::DIST_W-1:0]   acc_reg;
    logic [gbk_pkg::INV_W-1:0]    inv_reg;
    logic                         res_valid_reg;

    // datapath
    logic [15:0]                      ud_reg;
    logic                             last_reg;
    logic [gbk_pkg::DIST_W-1:0]       d2_reg;
    logic [44:0]                      x_reg;
    logic [4:0]                       n_reg;
    logic [TB-1:0]                    idx_reg;
    logic [23:0]                      r_reg;
    logic [gbk_pkg::EXP_VAL_W-1:0]    t0_reg;
    logic [31:0]                      diff_reg;
    logic [gbk_pkg::EXP_VAL_W-1:0]    v_reg;
    logic [gbk_pkg::KERNEL_W-1:0]     kern_reg;
    logic [gbk_pkg::KERNEL_W-1:0]     res_kernel_reg;
    logic [gbk_pkg::DIST_W-1:0]       res_dist_reg;

    logic                             accept;
    logic signed [16:0]               diff17;
    logic [16:0]                      abs17;
    logic [MW-1:0]                    mul_a;
    logic [MW-1:0]                    mul_b;
    logic [2*MW-1:0]                  prod;
    logic [gbk_pkg::DIST_W:0]         sum43;
    logic [gbk_pkg::DIST_W-1:0]       acc_sat;
    logic [gbk_pkg::X_W-1:0]          x_sum;
    logic [5:0]                       n_raw;
    logic [23:0]                      frac;
    logic [gbk_pkg::EXP_ADDR_W-1:0]   rom_addr;
    logic [gbk_pkg::EXP_VAL_W-1:0]    rom_q;
    logic [gbk_pkg::EXP_VAL_W:0]      rnd_sum;
    logic [gbk_pkg::EXP_VAL_W:0]      rnd_shift;

    gbk_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    gbk_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    gbk_exp_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    assign accept     = pair.valid && ctrl.in_ready;
    assign pair.ready = ctrl.in_ready;
    assign cfg.ready  = 1'b1;

    // |a - b| fits 16 bits
    assign diff17 = {pair.coord_a[15], pair.coord_a} - {pair.coord_b[15], pair.coord_b};
    assign abs17  = diff17[16] ? 17'(-diff17) : 17'(diff17);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_op)
            gbk_pkg::MUL_SQ:
            begin
                mul_a = {16'b0, ud_reg};
                mul_b = {16'b0, ud_reg};
            end
            gbk_pkg::MUL_XLO:
            begin
                mul_a = {11'b0, d2_reg[20:0]};
                mul_b = {8'b0, inv_reg};
            end
            gbk_pkg::MUL_XHI:
            begin
                mul_a = {11'b0, d2_reg[41:21]};
                mul_b = {8'b0, inv_reg};
            end
            gbk_pkg::MUL_LOG:
            begin
                mul_a = {2'b0, x_reg[37:8]};
                mul_b = gbk_pkg::LOG2E_Q30;
            end
            gbk_pkg::MUL_INTERP:
            begin
                mul_a = diff_reg;
                mul_b = {8'b0, r_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // saturating accumulate of the square
    assign sum43   = {1'b0, acc_reg} + {11'b0, prod[31:0]};
    assign acc_sat = sum43[gbk_pkg::DIST_W] ? gbk_pkg::ACC_MAX : sum43[gbk_pkg::DIST_W-1:0];

    // d2 * inv from two 21-bit halves of d2
    assign x_sum = {21'b0, x_reg} + {prod[44:0], 21'b0};

    // y = prod >> 30 in Q.24: exponent above, fraction below
    assign n_raw = prod[59:54];
    assign frac  = prod[53:30];

    assign rom_addr = ctrl.rom_next ? ({1'b0, idx_reg} + {{TB{1'b0}}, 1'b1})
                                    : {1'b0, idx_reg};

    // round half up, then scale by 2^-(16+n)
    assign rnd_sum   = {1'b0, v_reg} + (34'd1 << (6'd15 + {1'b0, n_reg}));
    assign rnd_shift = rnd_sum >> (6'd16 + {1'b0, n_reg});

    always_comb
    begin
        stat.pair_valid = pair.valid;
        stat.last       = last_reg;
        stat.trivial    = (d2_reg == '0) || (inv_reg == '0);
        stat.x_over     = x_sum > gbk_pkg::X_CAP_Q32;
        stat.n_over     = n_raw >= gbk_pkg::N_LIMIT;
        stat.out_free   = !res_valid_reg || result.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            inv_reg       <= 24'd32768;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.acc_step)
                acc_reg <= last_reg ? '0 : acc_sat;
            if (cfg.valid)
                inv_reg <= cfg.inv_bandwidth;
            if (ctrl.push)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ud_reg   <= abs17[15:0];
            last_reg <= pair.last;
        end
        if (ctrl.acc_step)
            d2_reg <= acc_sat;
        if (ctrl.x_lo_load)
            x_reg <= prod[44:0];
        else if (ctrl.x_sum_load)
            x_reg <= {7'b0, x_sum[37:0]};
        if (ctrl.split_load)
        begin
            n_reg   <= n_raw[4:0];
            idx_reg <= frac[23 -: TB];
            r_reg   <= {frac[23-TB:0], {TB{1'b0}}};
        end
        if (ctrl.t0_load)
            t0_reg <= rom_q;
        if (ctrl.diff_load)
            diff_reg <= 32'(t0_reg - rom_q);
        if (ctrl.v_load)
            v_reg <= t0_reg - {1'b0, prod[55:24]};
        if (ctrl.kern_one)
            kern_reg <= gbk_pkg::KERNEL_ONE;
        else if (ctrl.kern_zero)
            kern_reg <= '0;
        else if (ctrl.round_load)
            kern_reg <= rnd_shift[gbk_pkg::KERNEL_W-1:0];
        if (ctrl.push)
        begin
            res_kernel_reg <= kern_reg;
            res_dist_reg   <= d2_reg;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.kernel_value = res_kernel_reg;
    assign result.sq_distance  = res_dist_reg;

`ifndef SYNTHESIS
    // one coordinate pair at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && pair.ready) |=> !pair.ready)
        else $error("pair accepted while previous pair still in work");

    // accumulator restarts after the last coordinate
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.acc_step && last_reg) |=> (acc_reg == '0))
        else $error("accumulator not cleared after last coordinate");

    // never overwrite a result that has not been taken
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> (!result.valid || result.ready))
        else $error("result register overwritten");

    // kernel is at most 1.0, and exactly 1.0 at zero distance
    a_kernel_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.kernel_value <= gbk_pkg::KERNEL_ONE))
        else $error("kernel value above 1.0");

    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.sq_distance == '0))
            |-> (result.kernel_value == gbk_pkg::KERNEL_ONE))
        else $error("zero distance without unit kernel");
`endif

endmodule

`default_nettype wire

// ----- bench/gaussian_rbf_kernel_core_tb.sv -----
// ----------------------------------------------------------------------------
// gaussian_rbf_kernel_core_tb
// Streams coordinate pairs into the kernel core and checks every result
// against a bit-exact model of the accumulator, the exp table and the
// interpolation. The bench covers directed corner cases, accumulator
// saturation, a long result stall and random vector pairs over a range of
// inv_bandwidth settings.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_rbf_kernel_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KW = gbk_pkg::KERNEL_W;
    localparam int DW = gbk_pkg::DIST_W;
    localparam int CW = gbk_pkg::COORD_W;
    localparam int IW = gbk_pkg::INV_W;

    localparam int          LUT_SIZE      = 256;
    localparam int          SERIES_TERMS  = 24;
    localparam logic [63:0] LN2_FX        = 64'd2977044472;
    localparam logic [63:0] LOG2E_FX      = 64'd1549082005;
    localparam logic [63:0] ARG_LIMIT     = 64'd32 << 32;
    localparam logic [63:0] FRAC_MASK     = 64'hFF_FFFF;
    localparam logic [63:0] DIST_MAX      = (64'd1 << 42) - 64'd1;
    localparam logic [IW-1:0] INV_DEFAULT = 24'd32768;
    localparam logic [KW-1:0] KERNEL_UNIT = 17'd65536;

    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 38;
    localparam int SAT_LENGTH     = 1030;

    typedef enum int {
        SPREAD_TINY,
        SPREAD_NEAR,
        SPREAD_SMALL,
        SPREAD_FULL,
        SPREAD_EXTREME
    } spread_t;

    typedef struct packed {
        logic [KW-1:0] kernel;
        logic [DW-1:0] sq_dist;
    } kernel_result_t;

    logic clk;
    logic rst_n;

    gbk_pair_if   pair_ch ();
    gbk_result_if res_ch ();
    gbk_cfg_if    cfg_ch ();

    gaussian_rbf_kernel_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // model state
    logic [63:0]    exp2_lut [0:LUT_SIZE];
    logic [63:0]    dist_acc;
    logic [IW-1:0]  inv_bw;
    kernel_result_t kernel_results_due [$];

    int  mismatch_count;
    bit  no_idle;
    bit  hold_start;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // 2^(-k/size) in Q.32 from a truncated series of exp(-k*ln2/size)
    task automatic build_exp2_lut();
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] acc;
        for (int k = 0; k <= LUT_SIZE; k++)
        begin
            z    = (64'(k) * LN2_FX) / LUT_SIZE;
            term = 64'd1 << 32;
            acc  = term;
            for (int i = 1; i <= SERIES_TERMS; i++)
            begin
                term = ((term * z) >> 32) / 64'(i);
                if (i % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            exp2_lut[k] = acc;
        end
    endtask

    function automatic logic [KW-1:0] rbf_of_distance(input logic [63:0] d2,
                                                      input logic [IW-1:0] inv);
        logic [63:0] x32;
        logic [63:0] y24;
        logic [63:0] n;
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] r;
        logic [63:0] t0;
        logic [63:0] t1;
        logic [63:0] v;
        if (d2 == 0 || inv == 0)
            return KERNEL_UNIT;
        if (d2 > ARG_LIMIT / 64'(inv))
            return '0;
        x32 = d2 * 64'(inv);
        y24 = ((x32 >> 8) * LOG2E_FX) >> 30;
        n   = y24 >> 24;
        if (n >= 17)
            return '0;
        p   = (y24 & FRAC_MASK) * LUT_SIZE;
        idx = p >> 24;
        r   = p & FRAC_MASK;
        if (idx >= LUT_SIZE)
        begin
            idx = LUT_SIZE - 1;
            r   = FRAC_MASK;
        end
        t0 = exp2_lut[idx];
        t1 = exp2_lut[idx + 1];
        v  = t0 - (((t0 - t1) * r) >> 24);
        // round half up into Q1.16
        v  = (v + (64'd1 << (15 + n))) >> (16 + n);
        return v[KW-1:0];
    endfunction

    task automatic accumulate_pair(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                   input bit lst);
        int             diff;
        logic [63:0]    sum;
        kernel_result_t rec;
        diff = int'($signed(a)) - int'($signed(b));
        if (diff < 0)
            diff = -diff;
        sum = dist_acc + 64'(diff) * 64'(diff);
        if (sum > DIST_MAX)
            sum = DIST_MAX;
        if (!lst)
            dist_acc = sum;
        else
        begin
            rec.kernel  = rbf_of_distance(sum, inv_bw);
            rec.sq_dist = sum[DW-1:0];
            kernel_results_due.push_back(rec);
            dist_acc = '0;
        end
    endtask

    // one pair transaction; valid stays high for a following item
    task automatic send_pair(input int a, input int b, input bit lst);
        logic [CW-1:0] ca;
        logic [CW-1:0] cb;
        ca = a[CW-1:0];
        cb = b[CW-1:0];
        if (!no_idle && $urandom_range(99) < 16)
        begin
            pair_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pair_ch.valid   <= 1'b1;
        pair_ch.coord_a <= ca;
        pair_ch.coord_b <= cb;
        pair_ch.last    <= lst;
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
        accumulate_pair(ca, cb, lst);
    endtask

    task automatic end_burst();
        pair_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        while (kernel_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_inv_bandwidth(input logic [IW-1:0] val);
        settle();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.inv_bandwidth <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        inv_bw = val;
    endtask

    function automatic void pick_coords(input spread_t s, output int a, output int b);
        a = int'($urandom_range(0, 65535)) - 32768;
        case (s)
            SPREAD_TINY:
                b = a + int'($urandom_range(0, 32)) - 16;
            SPREAD_NEAR:
                b = a + int'($urandom_range(0, 256)) - 128;
            SPREAD_SMALL:
                b = a + int'($urandom_range(0, 2048)) - 1024;
            SPREAD_FULL:
                b = int'($urandom_range(0, 65535)) - 32768;
            default:
            begin
                case ($urandom_range(3))
                    0: a = -32768;
                    1: a = 32767;
                    2: a = 0;
                    default: a = -1;
                endcase
                case ($urandom_range(3))
                    0: b = -32768;
                    1: b = 32767;
                    2: b = 0;
                    default: b = -1;
                endcase
            end
        endcase
        if (b > 32767)
            b = 32767;
        if (b < -32768)
            b = -32768;
    endfunction

    function automatic spread_t pick_spread();
        int unsigned w;
        w = $urandom_range(99);
        if (w < 25)
            return SPREAD_TINY;
        if (w < 50)
            return SPREAD_NEAR;
        if (w < 80)
            return SPREAD_SMALL;
        if (w < 92)
            return SPREAD_FULL;
        return SPREAD_EXTREME;
    endfunction

    task automatic send_vector(input int len, input spread_t s);
        int a;
        int b;
        for (int i = 0; i < len; i++)
        begin
            pick_coords(s, a, b);
            send_pair(a, b, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        // reset value of inv_bandwidth first
        send_pair(0, 0, 1);
        send_pair(32767, -32768, 1);
        send_pair(-32768, 32767, 1);
        send_pair(256, 0, 1);
        send_pair(128, 0, 1);
        send_pair(-1, 0, 1);
        send_pair(32767, 32767, 1);
        send_pair(-32768, -32768, 1);
        send_pair(1, 0, 0);
        send_pair(-1, 1, 0);
        send_pair(5, 2, 1);
        end_burst();
        // zero inv_bandwidth gives unity whatever the distance
        write_inv_bandwidth('0);
        send_pair(32767, -32768, 0);
        send_pair(-32768, 32767, 1);
        send_pair(300, -300, 1);
        end_burst();
        write_inv_bandwidth({IW{1'b1}});
        send_pair(1, 0, 1);
        send_pair(16, 0, 1);
        send_pair(64, -64, 1);
        send_pair(0, 0, 1);
        end_burst();
        write_inv_bandwidth(24'd1);
        send_pair(32767, -32768, 1);
        send_pair(-32768, 32767, 0);
        send_pair(32767, -32768, 1);
        end_burst();
    endtask

    // accumulator holds at its maximum, then clears on last
    task automatic test_saturation();
        write_inv_bandwidth(24'd1);
        no_idle = 1'b1;
        for (int i = 0; i < SAT_LENGTH; i++)
        begin
            if ($urandom_range(1))
                send_pair(32767, -32768, i == SAT_LENGTH - 1);
            else
                send_pair(-32768, 32767, i == SAT_LENGTH - 1);
        end
        send_pair(256, 0, 0);
        send_pair(0, 256, 1);
        end_burst();
        no_idle = 1'b0;
    endtask

    // result side stalls while pairs keep coming, so the input backs up
    task automatic test_backpressure();
        write_inv_bandwidth(INV_DEFAULT);
        hold_start = 1'b1;
        for (int i = 0; i < 12; i++)
            send_vector(1, SPREAD_NEAR);
        end_burst();
    endtask

    task automatic test_random();
        logic [IW-1:0] inv_val;
        int            sent;
        int            len;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: inv_val = INV_DEFAULT;
                1: inv_val = {IW{1'b1}};
                2: inv_val = '0;
                3: inv_val = 24'd1;
                4: inv_val = IW'($urandom_range(1, 4096));
                5: inv_val = IW'($urandom_range(0, 65535));
                6: inv_val = 24'd65536;
                default: inv_val = IW'($urandom);
            endcase
            write_inv_bandwidth(inv_val);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(7) == 0)
                    len = $urandom_range(8, 40);
                else
                    len = $urandom_range(1, 6);
                send_vector(len, pick_spread());
                sent += len;
            end
            end_burst();
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    initial
    begin
        int unsigned hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (no_idle)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        kernel_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (kernel_results_due.size() == 0)
            begin
                $display("%0t: result with none due, kernel_value %0d sq_distance %0d",
                         $time, res_ch.kernel_value, res_ch.sq_distance);
                mismatch_count++;
            end
            else
            begin
                want = kernel_results_due.pop_front();
                if (res_ch.kernel_value !== want.kernel)
                begin
                    $display("%0t: kernel_value expected %0d actual %0d",
                             $time, want.kernel, res_ch.kernel_value);
                    mismatch_count++;
                end
                if (res_ch.sq_distance !== want.sq_dist)
                begin
                    $display("%0t: sq_distance expected %0d actual %0d",
                             $time, want.sq_dist, res_ch.sq_distance);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n                = 1'b0;
        pair_ch.valid        = 1'b0;
        pair_ch.coord_a      = '0;
        pair_ch.coord_b      = '0;
        pair_ch.last         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.inv_bandwidth = '0;
        mismatch_count       = 0;
        no_idle              = 1'b0;
        hold_start           = 1'b0;
        build_exp2_lut();
        dist_acc = '0;
        inv_bw   = INV_DEFAULT;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_saturation();
        test_backpressure();
        test_random();

        settle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
